// ===== hdl/huffman_code_bit_packer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Huffman code bit packer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define HCBP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hcbp assertion failed");

// Checked on every rising clock edge, reset included.
`define HCBP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hcbp assertion failed");

`else

`define HCBP_ASSERT(lbl, clk, rst_n, prop)
`define HCBP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hdl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared widths, action codes and the front-to-back request type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned CODE_W  = 32;   // code_value field
  localparam int unsigned LEN_W   = 6;    // code_length / word_bit_count field
  localparam int unsigned PEND_W  = 31;   // pending bit buffer
  localparam int unsigned CNT_W   = 5;    // pending bit count
  localparam int unsigned MERGE_W = PEND_W + CODE_W;
  localparam int unsigned WORD_W  = 32;   // packed_word field

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  // One request handed from the front to the back.
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } hcbp_req_t;

endpackage

// ===== hdl/huffman_code_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Code table, MSB-first bit packing into words, and final flush.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): in_tuser carries the action (load, encode, flush).
//   A load writes the 256-entry code table for in_tdata's symbol; an encode
//   appends that symbol's code to the pending bits; a flush sends whatever
//   is pending as a short word with in-band bit count and out_tlast high.
//   Output stream (out_*): one request per packed word, earliest bit most
//   significant, right-aligned; out_tlast marks a flush word.
//   Path: an encode that completes a word reaches out_tvalid through the
//   table read register, the request queue and then the output register,
//   which the packer loads when it pops the request from the queue head.
//   Throughput: one request per cycle sustained while out_tready stays high;
//   the table is a single read port RAM read once per encode, and the packer
//   consumes one queued request per cycle unless its output word is stalled.
//   A load followed at once by an encode of the same symbol sees the new code.
//   Reset clears the pending bits, the queue and the output valid; the code
//   table is not cleared and must be loaded before its entries are encoded.
//   Receiver stall: the output register holds its word; the request queue
//   (FIFO_DEPTH entries) keeps taking input until it and the lookup stage
//   hold FIFO_DEPTH requests, then in_tready drops. Loads never produce output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit #(
  parameter int unsigned WORD_BITS    = 32,  // 8..32, bits per full word
  parameter int unsigned MAX_CODE_LEN = 32,  // 1..32, longest storable code
  parameter int unsigned FIFO_DEPTH   = 4    // >= 3 keeps one request per cycle while out_tready is high
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [7:0] symbol, [39:8] code_value,
                                  // [45:40] code_length, [47:46] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  // Packed words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] packed_word, [37:32] word_bit_count,
                                  // [39:38] zero
  output logic        out_tlast   // is_final
);

  localparam int unsigned LVL_W = $clog2(FIFO_DEPTH+1);

  logic                                push;
  hcbp_pkg::hcbp_req_t                 push_req;
  logic                                pop;
  logic                                head_valid;
  hcbp_pkg::hcbp_req_t                 head_req;
  logic [LVL_W-1:0]                    fifo_level;
  logic [hcbp_pkg::WORD_W-1:0]         out_word;
  logic [hcbp_pkg::LEN_W-1:0]          out_count;

  // Front: accept, classify, table write/lookup.
  hcbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .FIFO_DEPTH   (FIFO_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .action      (in_tuser),
    .symbol      (in_tdata[7:0]),
    .code_value  (in_tdata[39:8]),
    .code_length (in_tdata[45:40]),
    .fifo_level  (fifo_level),
    .push        (push),
    .push_req    (push_req)
  );

  // Queue between lookup and packer.
  hcbp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req),
    .level      (fifo_level)
  );

  // Back: bit packing and output register.
  hcbp_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_word   (out_word),
    .out_count  (out_count),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, out_count, out_word};

endmodule

// ===== hdl/hcbp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/hcbp_front.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer front end
// Accepts requests, writes loads into the code table, looks up encodes and
// hands encode/flush requests to the queue in the cycle after acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_unit_assert.svh"

module hcbp_front #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned FIFO_DEPTH   = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic [hcbp_pkg::SYM_W-1:0]          symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]         code_value,
  input  logic [hcbp_pkg::LEN_W-1:0]          code_length,
  input  logic [$clog2(FIFO_DEPTH+1)-1:0]     fifo_level,
  output logic                                push,
  output hcbp_pkg::hcbp_req_t                 push_req
);

  localparam int unsigned RAM_W = MAX_CODE_LEN + hcbp_pkg::LEN_W;
  localparam int unsigned LVL_W = $clog2(FIFO_DEPTH+1);
  localparam logic [hcbp_pkg::LEN_W-1:0] MAX_LEN = hcbp_pkg::LEN_W'(MAX_CODE_LEN);
  localparam logic [LVL_W-1:0]           DEPTH_L = LVL_W'(FIFO_DEPTH);

  logic                        accept;
  logic                        is_load;
  logic                        is_encode;
  logic                        is_flush;
  logic [hcbp_pkg::LEN_W-1:0]  len_sat;
  logic [hcbp_pkg::CODE_W-1:0] code_mask;
  logic [hcbp_pkg::CODE_W-1:0] code_masked;
  logic [RAM_W-1:0]            ram_wdata;
  logic [RAM_W-1:0]            ram_rdata;
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic                        s1_flush_r;
  logic                        s1_flush_nxt;

  // Credit check: everything in the queue plus the lookup stage must leave a slot.
  assign in_ready = ({1'b0, fifo_level} + {{LVL_W{1'b0}}, s1_valid_r}) < {1'b0, DEPTH_L};
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_flush  = 1'b0;
    case (action)
      hcbp_pkg::ACT_LOAD:   is_load   = 1'b1;
      hcbp_pkg::ACT_ENCODE: is_encode = 1'b1;
      hcbp_pkg::ACT_FLUSH:  is_flush  = 1'b1;
      default: ;  // unknown action is dropped
    endcase
  end

  // Table load: saturate the length, drop code bits above it.
  assign len_sat     = (code_length > MAX_LEN) ? MAX_LEN : code_length;
  assign code_mask   = hcbp_pkg::CODE_W'((33'd1 << len_sat) - 33'd1);
  assign code_masked = code_value & code_mask;
  assign ram_wdata   = {len_sat, code_masked[MAX_CODE_LEN-1:0]};

  hcbp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (256)
  ) u_table (
    .clk   (clk),
    .we    (accept && is_load),
    .waddr (symbol),
    .wdata (ram_wdata),
    .re    (accept && is_encode),
    .raddr (symbol),
    .rdata (ram_rdata)
  );

  assign s1_valid_nxt = accept && (is_encode || is_flush);
  assign s1_flush_nxt = is_flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_flush_r <= s1_flush_nxt;
  end

  assign push              = s1_valid_r;
  assign push_req.is_flush = s1_flush_r;
  assign push_req.len      = ram_rdata[RAM_W-1 -: hcbp_pkg::LEN_W];
  assign push_req.code     = hcbp_pkg::CODE_W'(ram_rdata[MAX_CODE_LEN-1:0]);

  // The lookup stage only ever holds a request the queue has room for.
  `HCBP_ASSERT(a_s1_has_slot, clk, rst_n, s1_valid_r |-> (fifo_level < DEPTH_L))

endmodule

// ===== hdl/hcbp_fifo.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer request queue
// Small flop-based queue decoupling the front end from the packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_unit_assert.svh"

module hcbp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  hcbp_pkg::hcbp_req_t          push_req,
  input  logic                         pop,
  output logic                         head_valid,
  output hcbp_pkg::hcbp_req_t          head_req,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned LVL_W = $clog2(DEPTH+1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  hcbp_pkg::hcbp_req_t entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r;
  logic [IDX_W-1:0] wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [IDX_W-1:0] rd_ptr_nxt;
  logic [LVL_W-1:0] level_r;
  logic [LVL_W-1:0] level_nxt;

  assign wr_ptr_nxt = !push ? wr_ptr_r :
                      (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + IDX_W'(1);
  assign rd_ptr_nxt = !pop ? rd_ptr_r :
                      (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + IDX_W'(1);

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_req;
    end
  end

  assign head_valid = (level_r != '0);
  assign head_req   = entries[rd_ptr_r];
  assign level      = level_r;

  `HCBP_ASSERT(a_no_overflow, clk, rst_n, (push && !pop) |-> (level_r < LVL_W'(DEPTH)))
  `HCBP_ASSERT(a_no_underflow, clk, rst_n, pop |-> (level_r != '0))

endmodule

// ===== hdl/hcbp_back.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer back end
// Merges codes into the pending buffer, cuts full words, handles flush and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_unit_assert.svh"

module hcbp_back #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  hcbp_pkg::hcbp_req_t           head_req,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hcbp_pkg::WORD_W-1:0]   out_word,
  output logic [hcbp_pkg::LEN_W-1:0]    out_count,
  output logic                          out_last
);

  localparam int unsigned PW = hcbp_pkg::PEND_W;
  localparam int unsigned MW = hcbp_pkg::MERGE_W;
  localparam int unsigned LW = hcbp_pkg::LEN_W;
  localparam int unsigned WW = hcbp_pkg::WORD_W;
  localparam logic [LW-1:0] WB_L      = LW'(WORD_BITS);
  localparam logic [WW-1:0] WORD_MASK = WW'((33'd1 << WORD_BITS) - 33'd1);

  logic [PW-1:0]                  pend_r;
  logic [PW-1:0]                  pend_nxt;
  logic [hcbp_pkg::CNT_W-1:0]     cnt_r;
  logic [hcbp_pkg::CNT_W-1:0]     cnt_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [WW-1:0]                  out_word_r;
  logic [WW-1:0]                  out_word_nxt;
  logic [LW-1:0]                  out_count_r;
  logic [LW-1:0]                  out_count_nxt;
  logic                           out_last_r;
  logic                           out_last_nxt;

  logic [LW-1:0] total;
  logic [MW-1:0] merged;
  logic          full;
  logic [LW-1:0] keep;
  logic [MW-1:0] aligned;
  logic [PW-1:0] keep_mask;
  logic          emit;

  assign pop = head_valid && (!out_valid_r || out_ready);

  // Encode datapath: shift-merge, then cut the oldest WORD_BITS bits.
  assign total     = {1'b0, cnt_r} + head_req.len;
  assign merged    = (MW'(pend_r) << head_req.len) | MW'(head_req.code);
  assign full      = (total >= WB_L);
  assign keep      = total - WB_L;
  assign aligned   = merged >> keep;
  assign keep_mask = PW'((32'd1 << keep[hcbp_pkg::CNT_W-1:0]) - 32'd1);

  always_comb begin
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    out_word_nxt  = out_word_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    if (pop) begin
      if (head_req.is_flush) begin
        if (cnt_r != '0) begin
          emit          = 1'b1;
          out_word_nxt  = WW'(pend_r);
          out_count_nxt = {1'b0, cnt_r};
          out_last_nxt  = 1'b1;
          pend_nxt      = '0;
          cnt_nxt       = '0;
        end
      end else if (!full) begin
        pend_nxt = merged[PW-1:0];
        cnt_nxt  = total[hcbp_pkg::CNT_W-1:0];
      end else if (!keep[LW-1]) begin
        // keep above the buffer size means overrun: request is dropped
        emit          = 1'b1;
        out_word_nxt  = aligned[WW-1:0] & WORD_MASK;
        out_count_nxt = WB_L;
        out_last_nxt  = 1'b0;
        pend_nxt      = merged[PW-1:0] & keep_mask;
        cnt_nxt       = keep[hcbp_pkg::CNT_W-1:0];
      end
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

  `HCBP_ASSERT(a_flush_empties, clk, rst_n,
    (pop && head_req.is_flush) |=> (cnt_r == '0))
  `HCBP_ASSERT(a_full_word_count, clk, rst_n,
    (out_valid_r && !out_last_r) |-> (out_count_r == WB_L))
  `HCBP_ASSERT(a_flush_nonempty, clk, rst_n,
    (out_valid_r && out_last_r) |-> (out_count_r != '0))

endmodule
